// ===== rtl/mps_pkg.sv =====
package mps_pkg;

    localparam int NOTE_DEPTH_DEF = 1024;

    localparam int DIV_NW  = 44;   // dividend and quotient width
    localparam int DIV_VW  = 24;   // divisor width
    localparam int PWM_W   = 37;
    localparam int DUTY_W  = 7;
    localparam int MS_W    = 19;
    localparam int TOTAL_W = 21;   // seven quotients below 2^18 summed

    localparam logic [PWM_W-1:0]  PERIOD_NUM    = 37'd100000000000;
    localparam logic [17:0]       DUR_NUM       = 18'd240000;
    localparam logic [17:0]       DUR_NUM_TRIP  = 18'd160000;
    localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd100;
    localparam logic [DIV_VW-1:0] DUTY_DIV      = 24'd100;
    localparam logic [DIV_NW-1:0] DUTY_ROUND    = 44'd50;

    localparam logic [9:0]        BEAT_RST      = 10'd120;
    localparam logic [7:0]        DEBOUNCE_RST  = 8'd20;
    localparam logic [DUTY_W-1:0] DUTY_RST      = 7'd70;
    localparam logic [7:0]        SINCE_MAX     = 8'hff;

    localparam logic [1:0] CFG_BEAT     = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [1:0] CFG_DUTY     = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PRESS  = 2'd1,
        OP_LOAD   = 2'd2,
        OP_COMMIT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PS_STOPPED = 2'd0,
        PS_PAUSED  = 2'd1,
        PS_PLAYING = 2'd2
    } play_t;

    typedef enum logic [3:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_START,
        SQ_PLAY,
        SQ_FETCH,
        SQ_PEEK,
        SQ_PERIOD,
        SQ_SCALE,
        SQ_DUTY,
        SQ_LEN,
        SQ_LENDIV,
        SQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  note_index;
        logic [23:0] note_freq;
        logic [7:0]  note_code;
    } in_t;

    typedef struct packed {
        logic [1:0]       play_state;
        logic             pwm_on;
        logic [PWM_W-1:0] period_ns;
        logic [PWM_W-1:0] duty_ns;
        logic [MS_W-1:0]  remaining_ms;
        logic             refused;
        logic             press_ignored;
    } out_t;

endpackage

// ===== rtl/mps_serial_div.sv =====
module mps_serial_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mps_pkg::DIV_NW-1:0] dividend,
    input  logic [mps_pkg::DIV_VW-1:0] divisor,
    output logic                       done,
    output logic [mps_pkg::DIV_NW-1:0] quotient
);

    localparam int CW = $clog2(mps_pkg::DIV_NW);
    localparam logic [CW-1:0] LAST = CW'(mps_pkg::DIV_NW - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [mps_pkg::DIV_VW-1:0] rem_reg;
    logic [mps_pkg::DIV_VW-1:0] rem_next;
    logic [mps_pkg::DIV_NW-1:0] quo_reg;
    logic [mps_pkg::DIV_NW-1:0] quo_next;
    logic [mps_pkg::DIV_VW-1:0] dvs_reg;
    logic [mps_pkg::DIV_VW:0]   shifted;
    logic [mps_pkg::DIV_VW+1:0] diff;
    logic                       ge;

    // one quotient bit a cycle, restoring form
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[mps_pkg::DIV_NW-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        ge       = !diff[mps_pkg::DIV_VW+1];
        rem_next = ge ? diff[mps_pkg::DIV_VW-1:0] : shifted[mps_pkg::DIV_VW-1:0];
        quo_next = {quo_reg[mps_pkg::DIV_NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/mps_serial_mul.sv =====
module mps_serial_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mps_pkg::PWM_W-1:0]  mcand,
    input  logic [mps_pkg::DUTY_W-1:0] mplier,
    output logic                       done,
    output logic [mps_pkg::DIV_NW-1:0] product
);

    localparam int CW = $clog2(mps_pkg::DUTY_W);
    localparam logic [CW-1:0] LAST = CW'(mps_pkg::DUTY_W - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [mps_pkg::DIV_NW-1:0] acc_reg;
    logic [mps_pkg::DIV_NW-1:0] mcand_reg;
    logic [mps_pkg::DUTY_W-1:0] mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift and add, one multiplier bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= mps_pkg::DIV_NW'(mcand);
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[mps_pkg::DIV_NW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[mps_pkg::DUTY_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/mps_note_store.sv =====
module mps_note_store #(
    parameter int NOTE_DEPTH = mps_pkg::NOTE_DEPTH_DEF,
    localparam int AW = $clog2(NOTE_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata,
    output logic          clearing
);

    logic [31:0]   mem [NOTE_DEPTH];
    logic [31:0]   rdata_reg;
    logic [AW-1:0] clr_reg;
    logic          clearing_reg;

    // sweep writes end markers into every entry after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == AW'(NOTE_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_reg] <= '0;
        else if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

// ===== rtl/melody_pwm_sequencer_unit.sv =====
// melody pwm sequencer: a note store (32-bit entries, frequency in the low 24 bits and
// length code in the top byte) drives a buzzer pwm through a stopped/paused/playing
// machine. one item is taken at a time and one result transfer follows each item.
// loads, commits, pauses, ignored presses and ticks that end no note while playing go
// from the item transfer to the done state and then to the registered result. an item
// that plays a note reads the store, divides for the period on the bit-serial divider,
// does the duty multiply and the divide by hundred, scans the length code and divides
// once for each set figure bit of the length, then makes its result transfer; a rest
// skips the period and duty steps, and a start from stopped first checks entry 0. the
// shared one-bit-a-cycle divider serves the period, duty and length steps. after reset
// the note store is swept to end markers, one entry a cycle, during which no item is
// taken; configuration writes are taken at any time. the next item is held off until
// the result has gone.
module melody_pwm_sequencer_unit #(
    parameter int NOTE_DEPTH = mps_pkg::NOTE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  mps_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output mps_pkg::out_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [9:0]    cfg_data
);

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(NOTE_DEPTH - 1);

    mps_pkg::seq_state_t state_reg, state_next;
    mps_pkg::play_t      fsm_reg, fsm_next;

    logic [AW-1:0]               ptr_reg, ptr_next;
    logic                        pvalid_reg, pvalid_next;
    logic [mps_pkg::MS_W-1:0]    cd_reg, cd_next;
    logic                        active_reg, active_next;
    logic [7:0]                  since_reg, since_next;
    logic [mps_pkg::PWM_W-1:0]   per_reg, per_next;
    logic [mps_pkg::PWM_W-1:0]   duty_reg, duty_next;
    logic                        pwm_reg, pwm_next;
    logic [31:0]                 note_reg, note_next;
    logic [2:0]                  bit_reg, bit_next;
    logic [mps_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        refused_reg, refused_next;
    logic                        ignored_reg, ignored_next;
    logic                        out_valid_reg, out_valid_next;
    mps_pkg::out_t               out_reg, out_next;

    logic [9:0]                  beat_reg;
    logic [7:0]                  deb_reg;
    logic [mps_pkg::DUTY_W-1:0]  dutyp_reg;

    logic                        accept;
    logic                        idx_ok;
    logic                        clearing;
    logic                        mem_we;
    logic [31:0]                 mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [31:0]                 mem_rdata;

    logic                        div_start;
    logic [mps_pkg::DIV_NW-1:0]  div_dividend;
    logic [mps_pkg::DIV_VW-1:0]  div_divisor;
    logic                        div_done;
    logic [mps_pkg::DIV_NW-1:0]  div_quo;
    logic                        mul_start;
    logic                        mul_done;
    logic [mps_pkg::DIV_NW-1:0]  mul_prod;

    logic [9:0]                  beat_eff;
    logic [mps_pkg::DUTY_W-1:0]  duty_eff;
    logic [15:0]                 len_divisor;
    logic [23:0]                 cur_freq;
    logic [7:0]                  cur_len;
    logic                        expiring;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != mps_pkg::SQ_IDLE) || out_valid_reg;
    assign cfg_ready  = 1'b1;
    assign idx_ok     = 32'(item.note_index) < 32'(NOTE_DEPTH);

    assign cur_freq    = note_reg[23:0];
    assign cur_len     = note_reg[31:24];
    assign beat_eff    = (beat_reg == '0) ? 10'd1 : beat_reg;
    assign duty_eff    = (dutyp_reg > mps_pkg::DUTY_MAX) ? mps_pkg::DUTY_MAX : dutyp_reg;
    assign len_divisor = 16'(beat_eff) << bit_reg;
    // countdown runs out on this tick
    assign expiring    = active_reg && (cd_reg <= 19'd1);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= mps_pkg::BEAT_RST;
            deb_reg   <= mps_pkg::DEBOUNCE_RST;
            dutyp_reg <= mps_pkg::DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mps_pkg::CFG_BEAT:     beat_reg  <= cfg_data;
                mps_pkg::CFG_DEBOUNCE: deb_reg   <= cfg_data[7:0];
                mps_pkg::CFG_DUTY:     dutyp_reg <= cfg_data[mps_pkg::DUTY_W-1:0];
                default:               ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mps_pkg::SQ_CLEAR:
                if (!clearing)
                    state_next = mps_pkg::SQ_IDLE;
            mps_pkg::SQ_IDLE:
                if (accept)
                begin
                    state_next = mps_pkg::SQ_DONE;
                    unique case (mps_pkg::op_t'(item.op))
                        mps_pkg::OP_TICK:
                            if (expiring && fsm_reg == mps_pkg::PS_PLAYING)
                                state_next = mps_pkg::SQ_PLAY;
                        mps_pkg::OP_PRESS:
                            if (since_reg >= deb_reg)
                            begin
                                if (fsm_reg == mps_pkg::PS_STOPPED)
                                    state_next = mps_pkg::SQ_START;
                                else if (fsm_reg == mps_pkg::PS_PAUSED)
                                    state_next = mps_pkg::SQ_PLAY;
                            end
                        mps_pkg::OP_LOAD,
                        mps_pkg::OP_COMMIT:
                            state_next = mps_pkg::SQ_DONE;
                    endcase
                end
            mps_pkg::SQ_START:
                state_next = (mem_rdata == '0) ? mps_pkg::SQ_DONE : mps_pkg::SQ_PLAY;
            mps_pkg::SQ_PLAY:
                state_next = pvalid_reg ? mps_pkg::SQ_FETCH : mps_pkg::SQ_DONE;
            mps_pkg::SQ_FETCH:
                state_next = (mem_rdata == '0) ? mps_pkg::SQ_DONE : mps_pkg::SQ_PEEK;
            mps_pkg::SQ_PEEK:
                state_next = (cur_freq != '0) ? mps_pkg::SQ_PERIOD : mps_pkg::SQ_LEN;
            mps_pkg::SQ_PERIOD:
                if (div_done)
                    state_next = mps_pkg::SQ_SCALE;
            mps_pkg::SQ_SCALE:
                if (mul_done)
                    state_next = mps_pkg::SQ_DUTY;
            mps_pkg::SQ_DUTY:
                if (div_done)
                    state_next = mps_pkg::SQ_LEN;
            mps_pkg::SQ_LEN:
                if (bit_reg == 3'd7)
                    state_next = mps_pkg::SQ_DONE;
                else if (cur_len[bit_reg])
                    state_next = mps_pkg::SQ_LENDIV;
            mps_pkg::SQ_LENDIV:
                if (div_done)
                    state_next = mps_pkg::SQ_LEN;
            mps_pkg::SQ_DONE:
                state_next = mps_pkg::SQ_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        fsm_next       = fsm_reg;
        ptr_next       = ptr_reg;
        pvalid_next    = pvalid_reg;
        cd_next        = cd_reg;
        active_next    = active_reg;
        since_next     = since_reg;
        per_next       = per_reg;
        duty_next      = duty_reg;
        pwm_next       = pwm_reg;
        note_next      = note_reg;
        bit_next       = bit_reg;
        total_next     = total_reg;
        refused_next   = refused_reg;
        ignored_next   = ignored_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        mem_raddr      = ptr_reg;
        div_start      = 1'b0;
        div_dividend   = mps_pkg::DIV_NW'(mps_pkg::PERIOD_NUM)
                         + mps_pkg::DIV_NW'(cur_freq[23:1]);
        div_divisor    = cur_freq;
        mul_start      = 1'b0;

        if (result_valid && !result_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            mps_pkg::SQ_CLEAR:
                ;
            mps_pkg::SQ_IDLE:
            begin
                // entry 0 is read ahead for a start from stopped
                mem_raddr = '0;
                if (accept)
                begin
                    refused_next = 1'b0;
                    ignored_next = 1'b0;
                    unique case (mps_pkg::op_t'(item.op))
                        mps_pkg::OP_TICK:
                        begin
                            if (since_reg != mps_pkg::SINCE_MAX)
                                since_next = since_reg + 1'b1;
                            if (expiring)
                            begin
                                cd_next     = '0;
                                active_next = 1'b0;
                                pwm_next    = 1'b0;
                            end
                            else if (active_reg)
                                cd_next = cd_reg - 1'b1;
                        end
                        mps_pkg::OP_PRESS:
                            if (since_reg < deb_reg)
                                ignored_next = 1'b1;
                            else
                            begin
                                since_next = '0;
                                if (fsm_reg == mps_pkg::PS_PAUSED)
                                    fsm_next = mps_pkg::PS_PLAYING;
                                else if (fsm_reg == mps_pkg::PS_PLAYING)
                                begin
                                    fsm_next = mps_pkg::PS_PAUSED;
                                    pwm_next = 1'b0;
                                end
                            end
                        mps_pkg::OP_LOAD:
                            if (fsm_reg == mps_pkg::PS_PLAYING)
                                refused_next = 1'b1;
                            else
                            begin
                                mem_we    = idx_ok;
                                mem_wdata = {item.note_code, item.note_freq};
                            end
                        mps_pkg::OP_COMMIT:
                            if (fsm_reg == mps_pkg::PS_PLAYING)
                                refused_next = 1'b1;
                            else
                            begin
                                mem_we      = idx_ok;
                                fsm_next    = mps_pkg::PS_STOPPED;
                                pvalid_next = 1'b0;
                                pwm_next    = 1'b0;
                            end
                    endcase
                end
            end
            mps_pkg::SQ_START:
            begin
                ptr_next = '0;
                if (mem_rdata == '0)
                    pvalid_next = 1'b0;
                else
                begin
                    pvalid_next = 1'b1;
                    fsm_next    = mps_pkg::PS_PLAYING;
                end
            end
            mps_pkg::SQ_PLAY:
                if (!pvalid_reg)
                    fsm_next = mps_pkg::PS_STOPPED;
            mps_pkg::SQ_FETCH:
            begin
                // peek at the entry after this one
                mem_raddr = ptr_reg + 1'b1;
                if (mem_rdata == '0)
                begin
                    pvalid_next = 1'b0;
                    fsm_next    = mps_pkg::PS_STOPPED;
                end
                else
                begin
                    note_next = mem_rdata;
                    ptr_next  = ptr_reg + 1'b1;
                    if (ptr_reg == LAST_ENTRY)
                    begin
                        pvalid_next = 1'b0;
                        fsm_next    = mps_pkg::PS_STOPPED;
                    end
                end
            end
            mps_pkg::SQ_PEEK:
            begin
                if (pvalid_reg && mem_rdata == '0)
                begin
                    pvalid_next = 1'b0;
                    fsm_next    = mps_pkg::PS_STOPPED;
                end
                bit_next   = '0;
                total_next = '0;
                if (cur_freq != '0)
                    div_start = 1'b1;
                else
                begin
                    per_next  = '0;
                    duty_next = '0;
                    pwm_next  = 1'b0;
                end
            end
            mps_pkg::SQ_PERIOD:
                if (div_done)
                begin
                    per_next  = div_quo[mps_pkg::PWM_W-1:0];
                    mul_start = 1'b1;
                end
            mps_pkg::SQ_SCALE:
            begin
                div_dividend = mul_prod + mps_pkg::DUTY_ROUND;
                div_divisor  = mps_pkg::DUTY_DIV;
                div_start    = mul_done;
            end
            mps_pkg::SQ_DUTY:
                if (div_done)
                begin
                    duty_next = div_quo[mps_pkg::PWM_W-1:0];
                    pwm_next  = 1'b1;
                end
            mps_pkg::SQ_LEN:
            begin
                div_dividend = mps_pkg::DIV_NW'(cur_len[7] ? mps_pkg::DUR_NUM_TRIP
                                                           : mps_pkg::DUR_NUM);
                div_divisor  = mps_pkg::DIV_VW'(len_divisor);
                if (bit_reg == 3'd7)
                begin
                    cd_next     = total_reg[mps_pkg::MS_W-1:0];
                    active_next = 1'b1;
                end
                else if (cur_len[bit_reg])
                    div_start = 1'b1;
                else
                    bit_next = bit_reg + 1'b1;
            end
            mps_pkg::SQ_LENDIV:
                if (div_done)
                begin
                    total_next = total_reg + mps_pkg::TOTAL_W'(div_quo[17:0]);
                    bit_next   = bit_reg + 1'b1;
                end
            mps_pkg::SQ_DONE:
            begin
                out_next.play_state    = fsm_reg;
                out_next.pwm_on        = pwm_reg;
                out_next.period_ns     = per_reg;
                out_next.duty_ns       = duty_reg;
                out_next.remaining_ms  = active_reg ? cd_reg : '0;
                out_next.refused       = refused_reg;
                out_next.press_ignored = ignored_reg;
                out_valid_next         = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mps_pkg::SQ_CLEAR;
            fsm_reg       <= mps_pkg::PS_STOPPED;
            ptr_reg       <= '0;
            pvalid_reg    <= 1'b0;
            cd_reg        <= '0;
            active_reg    <= 1'b0;
            since_reg     <= mps_pkg::SINCE_MAX;
            per_reg       <= '0;
            duty_reg      <= '0;
            pwm_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fsm_reg       <= fsm_next;
            ptr_reg       <= ptr_next;
            pvalid_reg    <= pvalid_next;
            cd_reg        <= cd_next;
            active_reg    <= active_next;
            since_reg     <= since_next;
            per_reg       <= per_next;
            duty_reg      <= duty_next;
            pwm_reg       <= pwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        note_reg    <= note_next;
        bit_reg     <= bit_next;
        total_reg   <= total_next;
        refused_reg <= refused_next;
        ignored_reg <= ignored_next;
        out_reg     <= out_next;
    end

    mps_note_store #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (mem_we),
        .waddr    (AW'(item.note_index)),
        .wdata    (mem_wdata),
        .raddr    (mem_raddr),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    mps_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // the multiply starts as the period lands, so it takes the new period
    mps_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (per_next),
        .mplier  (duty_eff),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
